[design/ipid_pkg.sv]
package ipid_pkg;

  localparam int ERR_FRAC  = 4;
  localparam int GAIN_W    = 24;
  localparam int TARGET_W  = 16;
  localparam int DRIVE_W   = 16;
  localparam int DRV_INT_W = 17;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int IDX_LSB   = 2;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_TARGET_LEVEL  = 3'd3,
    REG_DRIVE_CEILING = 3'd4,
    REG_DRIVE_FLOOR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [GAIN_W-1:0]   deriv_gain;
    logic [TARGET_W-1:0] target_level;
    logic [DRIVE_W-1:0]  drive_ceiling;
    logic [DRIVE_W-1:0]  drive_floor;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:     24'd104858,
    integ_gain:    24'd524,
    deriv_gain:    24'd0,
    target_level:  16'd29944,
    drive_ceiling: 16'd1750,
    drive_floor:   16'd1650
  };

endpackage

[design/ipid_regs.sv]
module ipid_regs
  import ipid_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:IDX_LSB]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:     cfg_nxt.prop_gain     = pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:    cfg_nxt.integ_gain    = pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:    cfg_nxt.deriv_gain    = pwdata[GAIN_W-1:0];
        REG_TARGET_LEVEL:  cfg_nxt.target_level  = pwdata[TARGET_W-1:0];
        REG_DRIVE_CEILING: cfg_nxt.drive_ceiling = pwdata[DRIVE_W-1:0];
        REG_DRIVE_FLOOR:   cfg_nxt.drive_floor   = pwdata[DRIVE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:     prdata = CFG_DW'(cfg_r.prop_gain);
      REG_INTEG_GAIN:    prdata = CFG_DW'(cfg_r.integ_gain);
      REG_DERIV_GAIN:    prdata = CFG_DW'(cfg_r.deriv_gain);
      REG_TARGET_LEVEL:  prdata = CFG_DW'(cfg_r.target_level);
      REG_DRIVE_CEILING: prdata = CFG_DW'(cfg_r.drive_ceiling);
      REG_DRIVE_FLOOR:   prdata = CFG_DW'(cfg_r.drive_floor);
      default:           prdata = '0;
    endcase
  end

endmodule

[design/ipid_err.sv]
module ipid_err
  import ipid_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int DIF_W       = 19
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  in_feedback_sample,
  input  logic [TARGET_W-1:0]     target_level,
  input  logic                    dn_ready,
  output logic                    dn_valid,
  output logic signed [DIF_W-1:0] d_prop,
  output logic signed [DIF_W-1:0] d_integ,
  output logic signed [DIF_W-1:0] d_deriv
);

  localparam int SHIFT_W = SAMPLE_BITS + ERR_FRAC;
  localparam int ERR_W   = ((SHIFT_W > TARGET_W) ? SHIFT_W : TARGET_W) + 1;

  logic                    valid_r;
  logic                    accept;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] e1_r;
  logic signed [ERR_W-1:0] e2_r;
  logic signed [DIF_W-1:0] ex;
  logic signed [DIF_W-1:0] e1x;
  logic signed [DIF_W-1:0] e2x;
  logic signed [DIF_W-1:0] d_prop_r;
  logic signed [DIF_W-1:0] d_integ_r;
  logic signed [DIF_W-1:0] d_deriv_r;

  assign in_stall = valid_r & ~dn_ready;
  assign accept   = in_valid & ~in_stall;

  assign err = $signed(ERR_W'({in_feedback_sample, {ERR_FRAC{1'b0}}}))
             - $signed(ERR_W'(target_level));

  assign ex  = DIF_W'(err);
  assign e1x = DIF_W'(e1_r);
  assign e2x = DIF_W'(e2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      e1_r    <= '0;
      e2_r    <= '0;
    end else begin
      if (!in_stall) begin
        valid_r <= in_valid;
      end
      if (accept) begin
        e1_r <= err;
        e2_r <= e1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_prop_r  <= ex - e1x;
      d_integ_r <= ex + e1x;
      d_deriv_r <= ex - e1x - e1x + e2x;
    end
  end

  assign dn_valid = valid_r;
  assign d_prop   = d_prop_r;
  assign d_integ  = d_integ_r;
  assign d_deriv  = d_deriv_r;

endmodule

[design/ipid_mul.sv]
module ipid_mul
  import ipid_pkg::*;
#(
  parameter int DIF_W = 19
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [DIF_W-1:0]          d_prop,
  input  logic signed [DIF_W-1:0]          d_integ,
  input  logic signed [DIF_W-1:0]          d_deriv,
  input  cfg_t                             cfg,
  input  logic                             dn_ready,
  output logic                             dn_valid,
  output logic signed [DIF_W+GAIN_W-1:0]   p_prop,
  output logic signed [DIF_W+GAIN_W-1:0]   p_integ,
  output logic signed [DIF_W+GAIN_W-1:0]   p_deriv
);

  localparam int PROD_W = DIF_W + GAIN_W;

  logic                     valid_r;
  logic                     advance;
  logic signed [GAIN_W:0]   kp;
  logic signed [GAIN_W:0]   ki;
  logic signed [GAIN_W:0]   kd;
  logic signed [PROD_W-1:0] p_prop_r;
  logic signed [PROD_W-1:0] p_integ_r;
  logic signed [PROD_W-1:0] p_deriv_r;

  assign kp = $signed({1'b0, cfg.prop_gain});
  assign ki = $signed({1'b0, cfg.integ_gain});
  assign kd = $signed({1'b0, cfg.deriv_gain});

  assign up_ready = ~valid_r | dn_ready;
  assign advance  = up_valid & up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_prop_r  <= PROD_W'(d_prop) * PROD_W'(kp);
      p_integ_r <= PROD_W'(d_integ) * PROD_W'(ki);
      p_deriv_r <= PROD_W'(d_deriv) * PROD_W'(kd);
    end
  end

  assign dn_valid = valid_r;
  assign p_prop   = p_prop_r;
  assign p_integ  = p_integ_r;
  assign p_deriv  = p_deriv_r;

endmodule

[design/ipid_acc.sv]
module ipid_acc
  import ipid_pkg::*;
#(
  parameter int PROD_W         = 43,
  parameter int GAIN_FRAC_BITS = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  logic signed [PROD_W-1:0] p_prop,
  input  logic signed [PROD_W-1:0] p_integ,
  input  logic signed [PROD_W-1:0] p_deriv,
  input  cfg_t                     cfg,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DRIVE_W-1:0]       out_drive_value,
  output logic                     out_clamped_high,
  output logic                     out_clamped_low
);

  localparam int ACC_W = PROD_W + 2;
  localparam int INC_W = ACC_W - ERR_FRAC;
  localparam int DRV_W = DRV_INT_W + GAIN_FRAC_BITS;
  localparam int SUM_W = ((INC_W > DRV_W) ? INC_W : DRV_W) + 1;

  logic                    valid_r;
  logic                    advance;
  logic signed [ACC_W-1:0] acc;
  logic signed [INC_W-1:0] inc;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] hi;
  logic signed [SUM_W-1:0] lo;
  logic signed [SUM_W-1:0] clamp;
  logic                    flag_hi;
  logic                    flag_lo;
  logic signed [DRV_W-1:0] prior_r;
  logic [DRIVE_W-1:0]      drive_r;
  logic                    hi_r;
  logic                    lo_r;

  assign acc = ACC_W'(p_prop) + ACC_W'(p_integ) + ACC_W'(p_deriv);
  // arithmetic shift floors toward minus infinity
  assign inc = $signed(acc[ACC_W-1:ERR_FRAC]);
  assign sum = SUM_W'(prior_r) + SUM_W'(inc);

  assign hi = SUM_W'($signed({1'b0, cfg.drive_ceiling, {GAIN_FRAC_BITS{1'b0}}}));
  assign lo = SUM_W'($signed({1'b0, cfg.drive_floor, {GAIN_FRAC_BITS{1'b0}}}));

  always_comb begin
    clamp   = sum;
    flag_hi = 1'b0;
    flag_lo = 1'b0;
    if (sum > hi) begin
      clamp   = hi;
      flag_hi = 1'b1;
    end else if (sum < lo) begin
      clamp   = lo;
      flag_lo = 1'b1;
    end
  end

  assign up_ready = ~valid_r | ~out_stall;
  assign advance  = up_valid & up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      prior_r <= '0;
    end else begin
      if (up_ready) begin
        valid_r <= up_valid;
      end
      if (advance) begin
        prior_r <= clamp[DRV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_r <= clamp[GAIN_FRAC_BITS +: DRIVE_W];
      hi_r    <= flag_hi;
      lo_r    <= flag_lo;
    end
  end

  assign out_valid        = valid_r;
  assign out_drive_value  = drive_r;
  assign out_clamped_high = hi_r;
  assign out_clamped_low  = lo_r;

endmodule

[design/incremental_pid_controller.sv]
// incremental pid controller, velocity form
// out_valid rises once the input transfer has passed the error, multiply and clamp registers
// throughput: one sample per cycle while out_stall is low; the drive feedback closes in the clamp stage
// a held result keeps earlier stages free, so inputs keep flowing until all stages fill
// reset (synchronous, rst_n low): pipeline empty, history and prior drive zero,
// registers at their default gains, setpoint and bounds
module incremental_pid_controller
  import ipid_pkg::*;
#(
  parameter int SAMPLE_BITS    = 12,
  parameter int GAIN_FRAC_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_feedback_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DRIVE_W-1:0]     out_drive_value,
  output logic                   out_clamped_high,
  output logic                   out_clamped_low
);

  localparam int SHIFT_W = SAMPLE_BITS + ERR_FRAC;
  localparam int ERR_W   = ((SHIFT_W > TARGET_W) ? SHIFT_W : TARGET_W) + 1;
  localparam int DIF_W   = ERR_W + 2;
  localparam int PROD_W  = DIF_W + GAIN_W;

  cfg_t                     cfg;
  logic                     s1_valid;
  logic                     s1_ready;
  logic signed [DIF_W-1:0]  d_prop;
  logic signed [DIF_W-1:0]  d_integ;
  logic signed [DIF_W-1:0]  d_deriv;
  logic                     s2_valid;
  logic                     s2_ready;
  logic signed [PROD_W-1:0] p_prop;
  logic signed [PROD_W-1:0] p_integ;
  logic signed [PROD_W-1:0] p_deriv;

  ipid_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ipid_err #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DIF_W       (DIF_W)
  ) u_err (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_feedback_sample (in_feedback_sample),
    .target_level       (cfg.target_level),
    .dn_ready           (s1_ready),
    .dn_valid           (s1_valid),
    .d_prop             (d_prop),
    .d_integ            (d_integ),
    .d_deriv            (d_deriv)
  );

  ipid_mul #(
    .DIF_W (DIF_W)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .d_prop   (d_prop),
    .d_integ  (d_integ),
    .d_deriv  (d_deriv),
    .cfg      (cfg),
    .dn_ready (s2_ready),
    .dn_valid (s2_valid),
    .p_prop   (p_prop),
    .p_integ  (p_integ),
    .p_deriv  (p_deriv)
  );

  ipid_acc #(
    .PROD_W         (PROD_W),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_acc (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (s2_valid),
    .up_ready         (s2_ready),
    .p_prop           (p_prop),
    .p_integ          (p_integ),
    .p_deriv          (p_deriv),
    .cfg              (cfg),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive_value  (out_drive_value),
    .out_clamped_high (out_clamped_high),
    .out_clamped_low  (out_clamped_low)
  );

endmodule

[design/ipid_checker.sv]
module ipid_checker
  import ipid_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DRIVE_W-1:0] out_drive_value,
  input logic               out_clamped_high,
  input logic               out_clamped_low
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_value)
      && $stable(out_clamped_high) && $stable(out_clamped_low))
    else $error("stalled result changed");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_clamped_high && out_clamped_low))
    else $error("both clamp flags set");

  // input backpressure only when the whole pipeline is full behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind incremental_pid_controller ipid_checker u_ipid_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_drive_value  (out_drive_value),
  .out_clamped_high (out_clamped_high),
  .out_clamped_low  (out_clamped_low)
);
